[rtl/pcc_pkg.sv]
`timescale 1ns / 1ps

package pcc_pkg;

  // Field widths are fixed by the interface
  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_OUT      = 16;
  localparam int ACC_WIDTH_DEF = 48;
  localparam int CFG_ADDR_W    = 5;

  // Register map, word index into the APB space
  typedef enum logic [2:0] {
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_OUT_LOW,
    REG_OUT_HIGH
  } reg_idx_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] target;
    logic signed [DATA_WIDTH-1:0] measured;
    logic        [DATA_WIDTH-1:0] step_time;
  } sample_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] drive;
    logic                         clamped;
  } result_t;

endpackage

[rtl/pid_controller_clamped.sv]
`timescale 1ns / 1ps

// Clamped PID controller, derivative taken on the measurement.
// Items enter on the sample channel (target, measured, step_time) and leave
// on the result channel (drive, clamped), both valid/ready; one result per
// item. Gains and drive limits sit in an APB register file (pready always
// high, reads return the sign-extended register); they must be written only
// while idle, which the block itself does not enforce. All products go
// through one radix-4 shift-add multiplier (2 bits a cycle, four products
// per item); the derivative quotient comes from a radix-4 restoring divider
// that runs beside the later multiplies. The four serial multiplies, not the
// divider, set the time an item takes.
// The result sits in an output register, so the next item is taken while an
// earlier result is still stalled; a finished item waits in its last step
// until that register is free.
// Reset clears the integral sum and stored measurement and loads the default
// gains (zero) and limits (full range).
module pid_controller_clamped #(
  parameter int ACC_WIDTH = pcc_pkg::ACC_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pcc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            sample_valid,
  output logic                            sample_ready,
  input  pcc_pkg::sample_t                sample,
  output logic                            result_valid,
  input  logic                            result_ready,
  output pcc_pkg::result_t                result
);
  import pcc_pkg::*;

  localparam int DW        = DATA_WIDTH;
  localparam int MC_W      = 2 * DW;
  localparam int PROD_W    = 3 * DW;
  localparam int MUL_STEPS = DW / 2;
  localparam int DIV_STEPS = PROD_W / 2;
  localparam int MCNT_W    = $clog2(MUL_STEPS + 1);
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int INC_W     = 2 * DW + 1;
  localparam int PT_W      = 2 * DW + 1;
  localparam int DER_W     = PROD_W + 1;
  localparam int PART_W    = PROD_W + 2;
  localparam int SUM_W     = ((ACC_WIDTH > PART_W) ? ACC_WIDTH : PART_W) + 1;
  localparam int ACC_X     = ACC_WIDTH + 1;
  localparam int LIM_W     = DW + FRAC_OUT;

  localparam logic signed [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic signed [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};
  localparam logic signed [DW-1:0]        LOW_RST = {1'b1, {(DW-1){1'b0}}};
  localparam logic signed [DW-1:0]        HIGH_RST = {1'b0, {(DW-1){1'b1}}};

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_D,
    S_MUL_IE,
    S_MUL_IT,
    S_MUL_P,
    S_TERMS,
    S_INTEG,
    S_SUM,
    S_OUT
  } state_t;

  function automatic logic [DW-1:0] mag(input logic signed [DW-1:0] v);
    mag = v[DW-1] ? DW'(-v) : v;
  endfunction

  // Register file
  logic signed [DW-1:0] prop_gain, integ_gain, deriv_gain, out_low, out_high;
  logic signed [DW-1:0] rd_val;
  logic                 cfg_wr;
  reg_idx_t             cfg_idx;

  assign pready = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_t'(paddr[CFG_ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      prop_gain  <= '0;
      integ_gain <= '0;
      deriv_gain <= '0;
      out_low    <= LOW_RST;
      out_high   <= HIGH_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_PROP_GAIN:  prop_gain  <= pwdata[DW-1:0];
        REG_INTEG_GAIN: integ_gain <= pwdata[DW-1:0];
        REG_DERIV_GAIN: deriv_gain <= pwdata[DW-1:0];
        REG_OUT_LOW:    out_low    <= pwdata[DW-1:0];
        REG_OUT_HIGH:   out_high   <= pwdata[DW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_PROP_GAIN:  rd_val = prop_gain;
      REG_INTEG_GAIN: rd_val = integ_gain;
      REG_DERIV_GAIN: rd_val = deriv_gain;
      REG_OUT_LOW:    rd_val = out_low;
      REG_OUT_HIGH:   rd_val = out_high;
      default:        rd_val = '0;
    endcase
    prdata = 32'(rd_val);
  end

  // Control and item state
  state_t                      state;
  logic [MCNT_W-1:0]           cnt;
  logic                        div_busy;
  logic [DCNT_W-1:0]           div_cnt;
  logic signed [ACC_WIDTH-1:0] integral;
  logic signed [DW-1:0]        prev_measured;

  // Per-item registers
  logic [DW-1:0]               err_mag, dm_mag, dt;
  logic                        err_neg, dm_neg;

  // Multiplier
  logic [MC_W-1:0]             mul_a;
  logic [MC_W+1:0]             mul_a3, pp, mc3;
  logic [DW-1:0]               mul_b;
  logic [PROD_W-1:0]           mul_acc;
  logic [MC_W-1:0]             mc_src;
  logic [DW-1:0]               mp_src;
  logic                        in_mul, mul_last, mul_load, mul_step;

  // Divider
  logic [PROD_W-1:0]           div_q;
  logic [DW-1:0]               div_rem;
  logic [DW+1:0]               div_d3, r4, d1, d2, r_sub;
  logic [1:0]                  qd;
  logic                        div_load, dt_zero;

  // Term assembly
  logic signed [INC_W-1:0]     inc;
  logic [INC_W-1:0]            inc_m;
  logic signed [PT_W-1:0]      pterm, p_pos;
  logic signed [DER_W-1:0]     deriv, q_pos;
  logic signed [PART_W-1:0]    partial;
  logic signed [SUM_W-1:0]     sum;
  logic signed [ACC_X-1:0]     integ_tmp;
  logic signed [LIM_W-1:0]     lim_hi, lim_lo;
  logic                        over, under, out_fire, neg_i, neg_p, neg_d;
  logic [DW-1:0]               drive_t;
  logic signed [DW:0]          err_full, dm_full;

  assign sample_ready = (state == S_IDLE);

  // Error and measurement change of the incoming item
  assign err_full = {sample.target[DW-1], sample.target}
                  - {sample.measured[DW-1], sample.measured};
  assign dm_full  = {sample.measured[DW-1], sample.measured}
                  - {prev_measured[DW-1], prev_measured};

  assign in_mul   = (state inside {S_MUL_D, S_MUL_IE, S_MUL_IT, S_MUL_P});
  assign mul_last = (cnt == MCNT_W'(MUL_STEPS));
  assign mul_load = in_mul && (cnt == '0);
  assign mul_step = in_mul && (cnt != '0);
  assign dt_zero  = (dt == '0);
  assign div_load = (state == S_MUL_IE) && (cnt == '0) && !dt_zero;

  assign neg_i = integ_gain[DW-1] ^ err_neg;
  assign neg_p = prop_gain[DW-1] ^ err_neg;
  assign neg_d = deriv_gain[DW-1] ^ dm_neg;

  // Operand selection for the shared multiplier
  always_comb begin
    case (state)
      S_MUL_D: begin
        mc_src = MC_W'(dm_mag);
        mp_src = mag(deriv_gain);
      end
      S_MUL_IE: begin
        mc_src = MC_W'(err_mag);
        mp_src = mag(integ_gain);
      end
      S_MUL_IT: begin
        mc_src = mul_acc[MC_W-1:0];
        mp_src = dt;
      end
      S_MUL_P: begin
        mc_src = MC_W'(err_mag);
        mp_src = mag(prop_gain);
      end
      default: begin
        mc_src = '0;
        mp_src = '0;
      end
    endcase
    mc3 = {2'b00, mc_src} + {1'b0, mc_src, 1'b0};
  end

  // Radix-4 partial product, top digit of the multiplier first
  always_comb begin
    case (mul_b[DW-1:DW-2])
      2'd0:    pp = '0;
      2'd1:    pp = {2'b00, mul_a};
      2'd2:    pp = {1'b0, mul_a, 1'b0};
      2'd3:    pp = mul_a3;
      default: pp = '0;
    endcase
  end

  // Radix-4 restoring division digit
  assign r4 = {div_rem, div_q[PROD_W-1 -: 2]};
  assign d1 = {2'b00, dt};
  assign d2 = {1'b0, dt, 1'b0};

  always_comb begin
    if (r4 >= div_d3) begin
      qd    = 2'd3;
      r_sub = r4 - div_d3;
    end else if (r4 >= d2) begin
      qd    = 2'd2;
      r_sub = r4 - d2;
    end else if (r4 >= d1) begin
      qd    = 2'd1;
      r_sub = r4 - d1;
    end else begin
      qd    = 2'd0;
      r_sub = r4;
    end
  end

  // Signed terms from magnitudes
  assign inc_m = {1'b0, mul_acc[PROD_W-1:DW]}
               + INC_W'(neg_i && (|mul_acc[DW-1:0]));
  assign p_pos = $signed({1'b0, mul_acc[MC_W-1:0]});
  assign q_pos = $signed({1'b0, div_q});

  // Integral update with saturation
  assign integ_tmp = ACC_X'(integral) + ACC_X'(inc);

  // Limit test and truncation toward zero
  assign lim_hi   = {out_high, {FRAC_OUT{1'b0}}};
  assign lim_lo   = {out_low, {FRAC_OUT{1'b0}}};
  assign over     = sum > SUM_W'(lim_hi);
  assign under    = sum < SUM_W'(lim_lo);
  assign drive_t  = sum[FRAC_OUT +: DW]
                  + DW'(sum[SUM_W-1] && (|sum[FRAC_OUT-1:0]));
  assign out_fire = (state == S_OUT) && (!result_valid || result_ready);

  // Datapath registers
  always_ff @(posedge clk) begin
    if (sample_valid && sample_ready) begin
      err_neg <= err_full[DW];
      err_mag <= err_full[DW] ? DW'(-err_full) : err_full[DW-1:0];
      dm_neg  <= dm_full[DW];
      dm_mag  <= dm_full[DW] ? DW'(-dm_full) : dm_full[DW-1:0];
      dt      <= sample.step_time;
    end

    if (mul_load) begin
      mul_a   <= mc_src;
      mul_a3  <= mc3;
      mul_b   <= mp_src;
      mul_acc <= '0;
    end else if (mul_step) begin
      mul_acc <= {mul_acc[PROD_W-3:0], 2'b00} + PROD_W'(pp);
      mul_b   <= {mul_b[DW-3:0], 2'b00};
    end

    // Dividend is |Kd*dmeas| shifted up by the output fraction
    if (div_load) begin
      div_q   <= {mul_acc[MC_W-1:0], {DW{1'b0}}};
      div_rem <= '0;
      div_d3  <= d1 + d2;
    end else if (div_busy) begin
      div_q   <= {div_q[PROD_W-3:0], qd};
      div_rem <= r_sub[DW-1:0];
    end

    // Integral increment, floored, once Ki*err*dt is ready
    if ((state == S_MUL_P) && (cnt == '0)) begin
      inc <= neg_i ? INC_W'(-$signed(inc_m)) : $signed(inc_m);
    end

    if ((state == S_TERMS) && !div_busy) begin
      pterm <= neg_p ? PT_W'(-p_pos) : p_pos;
      if (dt_zero) begin
        deriv <= '0;
      end else begin
        deriv <= neg_d ? q_pos : DER_W'(-q_pos);
      end
    end

    if (state == S_INTEG) begin
      partial <= PART_W'(pterm) + PART_W'(deriv);
    end

    if (state == S_SUM) begin
      sum <= SUM_W'(partial) + SUM_W'(integral);
    end
  end

  // Sequencer, controller state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      cnt           <= '0;
      div_busy      <= 1'b0;
      div_cnt       <= '0;
      integral      <= '0;
      prev_measured <= '0;
      result_valid  <= 1'b0;
    end else begin
      // Result taken with no new one behind it
      if (result_valid && result_ready && !out_fire) begin
        result_valid <= 1'b0;
      end

      if (in_mul) begin
        cnt <= mul_last ? '0 : cnt + 1'b1;
      end

      if (div_load) begin
        div_busy <= 1'b1;
        div_cnt  <= '0;
      end else if (div_busy) begin
        if (div_cnt == DCNT_W'(DIV_STEPS - 1)) begin
          div_busy <= 1'b0;
        end
        div_cnt <= div_cnt + 1'b1;
      end

      case (state)
        S_IDLE: begin
          if (sample_valid) begin
            prev_measured <= sample.measured;
            state         <= S_MUL_D;
          end
        end
        S_MUL_D: begin
          if (mul_last) state <= S_MUL_IE;
        end
        S_MUL_IE: begin
          if (mul_last) state <= S_MUL_IT;
        end
        S_MUL_IT: begin
          if (mul_last) state <= S_MUL_P;
        end
        S_MUL_P: begin
          if (mul_last) state <= S_TERMS;
        end
        S_TERMS: begin
          if (!div_busy) state <= S_INTEG;
        end
        S_INTEG: begin
          if (integ_tmp[ACC_X-1] != integ_tmp[ACC_X-2]) begin
            integral <= integ_tmp[ACC_X-1] ? ACC_MIN : ACC_MAX;
          end else begin
            integral <= integ_tmp[ACC_WIDTH-1:0];
          end
          state <= S_SUM;
        end
        S_SUM: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_fire) begin
            result_valid <= 1'b1;
            if (over) begin
              result.drive   <= out_high;
              result.clamped <= 1'b1;
              integral       <= '0;
            end else if (under) begin
              result.drive   <= out_low;
              result.clamped <= 1'b1;
              integral       <= '0;
            end else begin
              result.drive   <= drive_t;
              result.clamped <= 1'b0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Divider only runs alongside the later multiplies and the term wait
  a_div_window: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (state == S_MUL_IE || state == S_MUL_IT ||
                  state == S_MUL_P || state == S_TERMS))
    else $error("divider busy outside its window");

  // Partial remainder stays below the divisor
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> (div_rem < dt))
    else $error("division remainder out of range");

  // A clamp clears the integral sum
  a_clamp_clear: assert property (@(posedge clk) disable iff (rst)
    (out_fire && (over || under)) |=> (integral == '0))
    else $error("integral not cleared on clamp");

  // A clamped result carries one of the limits
  a_clamp_value: assert property (@(posedge clk) disable iff (rst)
    out_fire |=> (!result.clamped || result.drive == $past(out_high) ||
                  result.drive == $past(out_low)))
    else $error("clamped drive is not a limit");

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
  import pcc_pkg::*;

  localparam int ACC_W          = ACC_WIDTH_DEF;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int LONG_HOLD      = 400;
  localparam int DRAIN_CYCLES   = 60;
  localparam int PHASE_ITEMS    = 105;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0]           pwdata = '0;
  logic [31:0]           prdata;
  logic                  pready;
  logic                  sample_valid = 1'b0;
  logic                  sample_ready;
  sample_t               sample = '0;
  logic                  result_valid;
  logic                  result_ready = 1'b0;
  result_t               result;

  // Controller copy: gains, limits and loop state
  logic signed [DATA_WIDTH-1:0] kp, ki, kd, lim_lo, lim_hi;
  longint                       integ_acc;
  logic signed [DATA_WIDTH-1:0] last_meas;

  sample_t pending_samples[$];
  result_t expected_drives[$];

  int   mismatches = 0;
  int   results_seen = 0;
  int   quiet_cycles = 0;
  int   in_gap = 0;
  int   stall_left = 0;
  bit   hold_taken = 0;
  logic hold_req = 1'b0;
  logic calm = 1'b0;
  logic signed [DATA_WIDTH-1:0] walk_meas = '0;

  pid_controller_clamped u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .sample       (sample),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // One control step; every term stays well inside 64 bits at these widths
  function automatic result_t pid_predict(sample_t s);
    longint  acc_max, acc_min, err, incr, rate, p_part, total;
    result_t r;
    acc_max = (longint'(1) <<< (ACC_W - 1)) - 1;
    acc_min = -acc_max - 1;
    err = longint'($signed(s.target)) - longint'($signed(s.measured));
    // integral step, floored back to Q.16
    incr = (longint'(ki) * err * longint'(s.step_time)) >>> 16;
    if (incr > 0 && integ_acc > acc_max - incr)
      integ_acc = acc_max;
    else if (incr < 0 && integ_acc < acc_min - incr)
      integ_acc = acc_min;
    else
      integ_acc = integ_acc + incr;
    // derivative on the measurement, nothing when the step is zero
    rate = 0;
    if (s.step_time != 0)
      rate = -((longint'(kd) * (longint'($signed(s.measured)) - longint'(last_meas)) * 65536)
               / longint'(s.step_time));
    last_meas = s.measured;
    p_part = longint'(kp) * err;
    total = p_part + integ_acc + rate;
    // high limit wins when the limits cross
    if (total > longint'(lim_hi) * 65536) begin
      r.drive = lim_hi;
      r.clamped = 1'b1;
      integ_acc = 0;
    end else if (total < longint'(lim_lo) * 65536) begin
      r.drive = lim_lo;
      r.clamped = 1'b1;
      integ_acc = 0;
    end else begin
      r.drive = total / 65536;
      r.clamped = 1'b0;
    end
    return r;
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("result %0d: %s got %0d expected %0d", results_seen, what, got, want);
    mismatches++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic signed [DATA_WIDTH-1:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= {{16{val[15]}}, val};
    @(posedge clk);
    penable <= 1'b1;
    // register takes the value at this edge
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_PROP_GAIN:  kp = val;
      REG_INTEG_GAIN: ki = val;
      REG_DERIV_GAIN: kd = val;
      REG_OUT_LOW:    lim_lo = val;
      REG_OUT_HIGH:   lim_hi = val;
      default: ;
    endcase
  endtask

  task automatic apply_config(logic signed [15:0] p, logic signed [15:0] i,
                              logic signed [15:0] d, logic signed [15:0] lo,
                              logic signed [15:0] hi);
    write_reg(REG_PROP_GAIN, p);
    write_reg(REG_INTEG_GAIN, i);
    write_reg(REG_DERIV_GAIN, d);
    write_reg(REG_OUT_LOW, lo);
    write_reg(REG_OUT_HIGH, hi);
  endtask

  task automatic queue_sample(logic [15:0] tgt, logic [15:0] meas, logic [15:0] dt);
    sample_t s;
    s.target = tgt;
    s.measured = meas;
    s.step_time = dt;
    pending_samples.push_back(s);
  endtask

  // Block until every item has gone in and every result has come out
  task automatic wait_idle();
    @(posedge clk);
    while (pending_samples.size() != 0 || sample_valid || expected_drives.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic logic signed [15:0] small_gain(int span);
    int v;
    v = $urandom_range(0, 2 * span);
    return 16'(v - span);
  endfunction

  function automatic logic [15:0] corner_value();
    logic [15:0] v;
    case ($urandom_range(0, 3))
      0: v = 16'h7FFF;
      1: v = 16'h8000;
      2: v = 16'h0000;
      default: v = 16'hFFFF;
    endcase
    return v;
  endfunction

  // Mostly a slowly moving process with the setpoint nearby, some noise
  function automatic sample_t random_sample();
    sample_t s;
    int      mode, delta;
    mode = $urandom_range(0, 9);
    if (mode < 6) begin
      delta = $urandom_range(0, 1023);
      walk_meas = walk_meas + 16'(delta - 512);
      delta = $urandom_range(0, 4095);
      s.measured = walk_meas;
      s.target = walk_meas + 16'(delta - 2048);
    end else if (mode < 9) begin
      s.target = 16'($urandom);
      s.measured = 16'($urandom);
    end else begin
      s.target = corner_value();
      s.measured = corner_value();
    end
    case ($urandom_range(0, 9))
      0: s.step_time = '0;
      1: s.step_time = 16'($urandom_range(1, 15));
      2: s.step_time = 16'hFFFF;
      default: s.step_time = 16'($urandom);
    endcase
    return s;
  endfunction

  // Sample driver: hold until accepted, random gaps between items
  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready)
        expected_drives.push_back(pid_predict(sample));
      if (!(sample_valid && !sample_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          sample_valid <= 1'b0;
        end else if (pending_samples.size() == 0) begin
          sample_valid <= 1'b0;
        end else if (!calm && $urandom_range(0, 4) == 0) begin
          in_gap = $urandom_range(0, 4);
          sample_valid <= 1'b0;
        end else begin
          sample <= pending_samples.pop_front();
          sample_valid <= 1'b1;
        end
      end
    end
  end

  // Result monitor: compare against the oldest expected drive
  always @(posedge clk) begin : result_mon
    result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        results_seen++;
        if (expected_drives.size() == 0) begin
          flag_mismatch("item with nothing expected, drive", int'(result.drive), 0);
        end else begin
          want = expected_drives.pop_front();
          if (result.drive !== want.drive)
            flag_mismatch("drive", int'(result.drive), int'(want.drive));
          if (result.clamped !== want.clamped)
            flag_mismatch("clamped", int'(result.clamped), int'(want.clamped));
        end
      end
      // one long hold-off so the block backs up onto its input
      if (hold_req && !hold_taken) begin
        hold_taken = 1;
        stall_left = LONG_HOLD;
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(0, 4);
        result_ready <= 1'b0;
      end else begin
        result_ready <= 1'b1;
      end
    end
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (sample_valid && sample_ready) || (result_valid && result_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    kp = '0;
    ki = '0;
    kd = '0;
    lim_lo = -16'sd32768;
    lim_hi = 16'sd32767;
    integ_acc = 0;
    last_meas = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes, zero step, no kick on setpoint change, clamps
    apply_config(16'sh0100, 16'sh0100, 16'sh0100, -16'sd100, 16'sd100);
    queue_sample(16'h0000, 16'h0000, 16'h0000);
    queue_sample(16'h7FFF, 16'h8000, 16'hFFFF);
    queue_sample(16'h8000, 16'h7FFF, 16'hFFFF);
    queue_sample(16'h0100, 16'h0080, 16'h0001);
    queue_sample(16'h0200, 16'h0080, 16'h1000);
    queue_sample(16'h0300, 16'h0080, 16'h1000);
    queue_sample(16'h0080, 16'h0080, 16'h0000);
    queue_sample(16'h0000, 16'h7FFF, 16'h0000);
    queue_sample(16'h0000, 16'h0000, 16'h0001);
    queue_sample(16'h7FFF, 16'h7FFF, 16'h8000);
    queue_sample(16'h8000, 16'h8000, 16'hFFFF);
    queue_sample(16'h0010, 16'hFFF0, 16'h4000);
    queue_sample(16'hFF80, 16'h0000, 16'h0000);
    queue_sample(16'hFE80, 16'h0000, 16'h0100);
    queue_sample(16'h5555, 16'hAAAA, 16'h5555);
    queue_sample(16'hAAAA, 16'h5555, 16'hAAAA);
    wait_idle();

    // Crossed limits: the high limit is tested first
    apply_config(16'sh0100, 16'sh0000, 16'sh0000, 16'sd50, -16'sd50);
    queue_sample(16'h0000, 16'h0000, 16'h0000);
    queue_sample(16'h7FFF, 16'h0000, 16'h0100);
    queue_sample(16'h8000, 16'h0000, 16'h0100);
    queue_sample(16'hC000, 16'h3000, 16'hFFFF);
    wait_idle();

    // Random phases over a spread of settings
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: apply_config(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, -16'sd32768, 16'sd32767);
        1: apply_config(-16'sh8000, -16'sh8000, -16'sh8000, -16'sd32768, 16'sd32767);
        2: apply_config(small_gain(512), small_gain(512), small_gain(512),
                        16'sd200, -16'sd200);
        3: apply_config(small_gain(1024), small_gain(256), small_gain(256),
                        -16'sd500, 16'sd500);
        4: apply_config(small_gain(2048), small_gain(2048), small_gain(2048),
                        16'sd0, 16'sd0);
        5: apply_config(16'($urandom), 16'($urandom), 16'($urandom),
                        16'($urandom), 16'($urandom));
        6: apply_config(16'sh0000, small_gain(4096), 16'sh0000, -16'sd30000, 16'sd30000);
        default: apply_config(16'sh0200, 16'sh0040, 16'sh0080, -16'sd2000, 16'sd2000);
      endcase
      if (ph == 3)
        hold_req <= 1'b1;
      if (ph == 7)
        calm <= 1'b1;
      repeat (PHASE_ITEMS) pending_samples.push_back(random_sample());
      wait_idle();
    end

    if (mismatches == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
